// ===== rtl/core/lfds_pkg.sv =====
`default_nettype none

package lfds_pkg;

    localparam int unsigned ERR_W   = 11;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned SPD_W   = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned ACC_W   = 29;   // PD sum
    localparam int unsigned MA_W    = 30;   // multiplier operand A (error, error difference or turn rate)
    localparam int unsigned MB_W    = 17;   // multiplier operand B (gain)
    localparam int unsigned PROD_W  = 47;
    localparam int unsigned FWD_W   = 29;
    localparam int unsigned WHEEL_W = 48;

    localparam logic [MODE_W-1:0] MODE_FOLLOW  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORWARD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEFT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RIGHT   = 3'd4;

    localparam logic [DIR_W-1:0] DIR_RELEASE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD     = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACK    = 2'd2;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_FORWARD_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_TURN_GAIN    = 3'd3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 16'd256;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = 16'd0;
    localparam logic [GAIN_W-1:0] FORWARD_GAIN_RST = 16'd256;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST    = 16'd256;

    localparam logic [TICK_W-1:0] FORWARD_TICKS = 16'd100;
    localparam logic [TICK_W-1:0] TURN_TICKS    = 16'd17;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    // turn rate of the timed turns, Q8.8
    localparam logic signed [MA_W-1:0] TURN_RATE = 30'sd2560;

    localparam logic [SPD_W-1:0] SPEED_MAX = 8'd255;

    typedef enum logic [2:0] {
        OP_MUL_P,    // acc = err * prop_gain
        OP_MUL_D,    // acc += (err - last) * deriv_gain, save err
        OP_MUL_T,    // ang = omega * turn_gain
        OP_SUM,      // left/right = fwd -/+ ang
        OP_WHEEL     // map to direction and speed, load output
    } t_op;

    typedef enum logic {
        COND_NONE,
        COND_NOT_FOLLOW
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_ucode;

    localparam logic [STEP_W-1:0] STEP_START = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_T = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd4;

    function automatic t_ucode ucode_rom(input logic [STEP_W-1:0] step);
        t_ucode w;
        w = '{op: OP_WHEEL, cond: COND_NONE, target: STEP_START, last: 1'b1};
        case (step)
            3'd0:    w = '{op: OP_MUL_P, cond: COND_NOT_FOLLOW, target: STEP_MUL_T,
                           last: 1'b0};
            3'd1:    w = '{op: OP_MUL_D, cond: COND_NONE, target: STEP_START, last: 1'b0};
            3'd2:    w = '{op: OP_MUL_T, cond: COND_NONE, target: STEP_START, last: 1'b0};
            3'd3:    w = '{op: OP_SUM, cond: COND_NONE, target: STEP_START, last: 1'b0};
            3'd4:    w = '{op: OP_WHEEL, cond: COND_NONE, target: STEP_START, last: 1'b1};
            default: w = '{op: OP_WHEEL, cond: COND_NONE, target: STEP_START, last: 1'b1};
        endcase
        return w;
    endfunction

    // direction and saturated speed of one wheel, speed = |v| >> 16
    function automatic logic [DIR_W+SPD_W-1:0] wheel_cmd(input logic signed [WHEEL_W-1:0] v);
        logic [WHEEL_W-1:0]  mag;
        logic [DIR_W-1:0]    dir;
        logic [SPD_W-1:0]    spd;
        mag = v[WHEEL_W-1] ? WHEEL_W'(-v) : WHEEL_W'(v);
        if (v == '0) begin
            dir = DIR_RELEASE;
        end else if (v[WHEEL_W-1]) begin
            dir = DIR_BACK;
        end else begin
            dir = DIR_FWD;
        end
        spd = (|mag[WHEEL_W-1:16+SPD_W]) ? SPEED_MAX : mag[16+SPD_W-1:16];
        return {dir, spd};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/line_follow_drive_sequencer_core.sv =====
`default_nettype none
// A tick runs the five-step microprogram in follow mode and the four-step one in any other;
// a set-mode transaction is done in the cycle it is accepted and gives no result.
// The steps share one 30x17 multiplier, and no new tick is accepted until the final step
// has loaded the result; a stalled result holds the final step.
// Reset (i_rst_n low, synchronous): mode stop, tick count and previous error zero,
// gains to their defaults, sequencer idle, output empty.
module line_follow_drive_sequencer_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_cmd,
    input  wire signed [lfds_pkg::ERR_W-1:0] i_line_error,
    input  wire [lfds_pkg::MODE_W-1:0]     i_new_mode,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [lfds_pkg::DIR_W-1:0]     o_left_dir,
    output logic [lfds_pkg::SPD_W-1:0]     o_left_speed,
    output logic [lfds_pkg::DIR_W-1:0]     o_right_dir,
    output logic [lfds_pkg::SPD_W-1:0]     o_right_speed,
    output logic [lfds_pkg::MODE_W-1:0]    o_mode_now,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [lfds_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire [lfds_pkg::GAIN_W-1:0]     i_cfg_data
);
    import lfds_pkg::*;

    // control state
    logic                     r_busy;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    logic [MODE_W-1:0]        r_mode;
    logic [TICK_W-1:0]        r_tick;
    logic signed [ERR_W-1:0]  r_prev;
    logic [GAIN_W-1:0]        r_prop_gain;
    logic [GAIN_W-1:0]        r_deriv_gain;
    logic [GAIN_W-1:0]        r_forward_gain;
    logic [GAIN_W-1:0]        r_turn_gain;

    // datapath
    logic [MODE_W-1:0]         r_cur_mode;
    logic [MODE_W-1:0]         r_mode_after;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_ang;
    logic signed [WHEEL_W-1:0] r_left;
    logic signed [WHEEL_W-1:0] r_right;
    logic [DIR_W-1:0]          r_left_dir;
    logic [SPD_W-1:0]          r_left_speed;
    logic [DIR_W-1:0]          r_right_dir;
    logic [SPD_W-1:0]          r_right_speed;
    logic [MODE_W-1:0]         r_mode_now;

    logic [TICK_W-1:0]         n_tick;
    logic [MODE_W-1:0]         n_mode;
    logic                      in_acc;
    logic                      out_blocked;
    logic                      step_go;
    t_ucode                    cw;
    logic                      jump;
    logic signed [ERR_W:0]     err_diff;
    logic signed [MA_W-1:0]    omega;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [FWD_W-1:0]          fwd;
    logic signed [WHEEL_W-1:0] fwd_s;
    logic signed [WHEEL_W-1:0] ang_s;
    logic [DIR_W+SPD_W-1:0]    left_cmd;
    logic [DIR_W+SPD_W-1:0]    right_cmd;

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !r_busy;
    assign out_blocked = r_out_valid && i_out_stall;
    assign cw          = ucode_rom(r_step);
    assign jump        = (cw.cond == COND_NOT_FOLLOW) && (r_cur_mode != MODE_FOLLOW);
    // hold the final step while the previous result is still waiting
    assign step_go     = r_busy && !(cw.last && out_blocked);

    // tick count and mode after a control tick
    always_comb begin
        n_tick = (r_tick == TICK_MAX) ? r_tick : r_tick + 1'b1;
        n_mode = r_mode;
        case (r_mode)
            MODE_FORWARD: if (n_tick > FORWARD_TICKS) n_mode = MODE_STOP;
            MODE_LEFT:    if (n_tick > TURN_TICKS) n_mode = MODE_STOP;
            MODE_RIGHT:   if (n_tick > TURN_TICKS) n_mode = MODE_STOP;
            default:      n_mode = r_mode;
        endcase
    end

    always_comb begin
        err_diff = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_prev);
        case (r_cur_mode)
            MODE_FOLLOW: omega = -MA_W'(r_acc);
            MODE_LEFT:   omega = TURN_RATE;
            MODE_RIGHT:  omega = -TURN_RATE;
            default:     omega = '0;
        endcase
        case (cw.op)
            OP_MUL_P: begin
                mul_a = MA_W'(r_err);
                mul_b = MB_W'(signed'(r_prop_gain));
            end
            OP_MUL_D: begin
                mul_a = MA_W'(err_diff);
                mul_b = MB_W'(signed'(r_deriv_gain));
            end
            default: begin
                mul_a = omega;
                mul_b = signed'({1'b0, r_turn_gain});
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // forward term: 20 * forward_gain * 256 = forward_gain * (4096 + 1024)
    always_comb begin
        fwd = ((r_cur_mode == MODE_FOLLOW) || (r_cur_mode == MODE_FORWARD))
            ? FWD_W'({r_forward_gain, 12'b0}) + FWD_W'({r_forward_gain, 10'b0})
            : '0;
        fwd_s     = signed'(WHEEL_W'(fwd));
        ang_s     = WHEEL_W'(r_ang);
        left_cmd  = wheel_cmd(r_left);
        right_cmd = wheel_cmd(r_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_step         <= STEP_START;
            r_out_valid    <= 1'b0;
            r_mode         <= MODE_STOP;
            r_tick         <= '0;
            r_prev         <= '0;
            r_prop_gain    <= PROP_GAIN_RST;
            r_deriv_gain   <= DERIV_GAIN_RST;
            r_forward_gain <= FORWARD_GAIN_RST;
            r_turn_gain    <= TURN_GAIN_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                    REG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data;
                    REG_FORWARD_GAIN: r_forward_gain <= i_cfg_data;
                    REG_TURN_GAIN:    r_turn_gain    <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                if (i_cmd) begin
                    // drop unknown mode codes
                    if (i_new_mode <= MODE_RIGHT) begin
                        r_mode <= i_new_mode;
                        r_tick <= '0;
                    end
                end else begin
                    r_tick <= n_tick;
                    r_mode <= n_mode;
                    r_busy <= 1'b1;
                    r_step <= STEP_START;
                end
            end
            if (step_go) begin
                if (cw.op == OP_MUL_D) begin
                    r_prev <= r_err;
                end
                if (cw.last) begin
                    r_busy      <= 1'b0;
                    r_step      <= STEP_START;
                    r_out_valid <= 1'b1;
                end else if (jump) begin
                    r_step <= cw.target;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !i_cmd) begin
            r_cur_mode   <= r_mode;
            r_mode_after <= n_mode;
            r_err        <= i_line_error;
        end
        if (step_go) begin
            case (cw.op)
                OP_MUL_P: r_acc <= ACC_W'(mul_p);
                OP_MUL_D: r_acc <= r_acc + ACC_W'(mul_p);
                OP_MUL_T: r_ang <= mul_p;
                OP_SUM: begin
                    r_left  <= fwd_s - ang_s;
                    r_right <= fwd_s + ang_s;
                end
                OP_WHEEL: begin
                    r_left_dir    <= left_cmd[DIR_W+SPD_W-1:SPD_W];
                    r_left_speed  <= left_cmd[SPD_W-1:0];
                    r_right_dir   <= right_cmd[DIR_W+SPD_W-1:SPD_W];
                    r_right_speed <= right_cmd[SPD_W-1:0];
                    r_mode_now    <= r_mode_after;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_dir    = r_left_dir;
    assign o_left_speed  = r_left_speed;
    assign o_right_dir   = r_right_dir;
    assign o_right_speed = r_right_speed;
    assign o_mode_now    = r_mode_now;

    a_set_mode_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd) |=> !r_busy)
        else $error("set-mode transaction started the sequencer");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cmd) |=> (r_busy && r_step == STEP_START))
        else $error("tick did not start the microprogram");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_LAST))
        else $error("step counter ran past the program");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && cw.last))
        else $error("result loaded outside the final step");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode <= MODE_RIGHT))
        else $error("mode register holds an unknown code");

endmodule

`default_nettype wire

// ===== verif/lfds_drive_checker.sv =====
module lfds_drive_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    input  wire                            i_in_stall,
    input  wire                            i_cmd,
    input  wire [lfds_pkg::ERR_W-1:0]      i_line_error,
    input  wire [lfds_pkg::MODE_W-1:0]     i_new_mode,
    input  wire                            i_out_valid,
    input  wire                            i_out_stall,
    input  wire [lfds_pkg::DIR_W-1:0]      i_left_dir,
    input  wire [lfds_pkg::SPD_W-1:0]      i_left_speed,
    input  wire [lfds_pkg::DIR_W-1:0]      i_right_dir,
    input  wire [lfds_pkg::SPD_W-1:0]      i_right_speed,
    input  wire [lfds_pkg::MODE_W-1:0]     i_mode_now,
    input  wire                            i_cfg_valid,
    input  wire                            i_cfg_ready,
    input  wire [lfds_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire [lfds_pkg::GAIN_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfds_pkg::*;

    localparam longint CRUISE_SPEED = 20;
    localparam int     PRINT_CAP    = 40;

    typedef struct packed {
        logic [DIR_W-1:0]  left_dir;
        logic [SPD_W-1:0]  left_speed;
        logic [DIR_W-1:0]  right_dir;
        logic [SPD_W-1:0]  right_speed;
        logic [MODE_W-1:0] mode;
    } t_wheel_cmd;

    t_wheel_cmd wheel_cmds_due[$];

    logic [MODE_W-1:0]        drive_mode;
    logic [TICK_W-1:0]        ticks_in_mode;
    logic signed [ERR_W-1:0]  prev_err;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0]        kf;
    logic [GAIN_W-1:0]        kt;
    int                       mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Q16.16 wheel value to direction and saturated speed
    function automatic void split_wheel(input longint v, output logic [DIR_W-1:0] dir,
                                        output logic [SPD_W-1:0] spd);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> 16;
        if (v > 0) begin
            dir = DIR_FWD;
        end else if (v < 0) begin
            dir = DIR_BACK;
        end else begin
            dir = DIR_RELEASE;
        end
        spd = (mag > longint'(SPEED_MAX)) ? SPEED_MAX : mag[SPD_W-1:0];
    endfunction

    function automatic void predict_tick(input logic signed [ERR_W-1:0] err);
        longint     vx;
        longint     omega;
        longint     pd;
        longint     fwd;
        longint     ang;
        t_wheel_cmd r;
        vx    = 0;
        omega = 0;
        if (ticks_in_mode != TICK_MAX) begin
            ticks_in_mode = ticks_in_mode + 1'b1;
        end
        case (drive_mode)
            MODE_FOLLOW: begin
                pd = longint'(err) * longint'(kp)
                   + (longint'(err) - longint'(prev_err)) * longint'(kd);
                vx       = CRUISE_SPEED;
                omega    = -pd;
                prev_err = err;
            end
            MODE_FORWARD: begin
                vx = CRUISE_SPEED;
                if (ticks_in_mode > FORWARD_TICKS) drive_mode = MODE_STOP;
            end
            MODE_LEFT: begin
                omega = longint'(TURN_RATE);
                if (ticks_in_mode > TURN_TICKS) drive_mode = MODE_STOP;
            end
            MODE_RIGHT: begin
                omega = -longint'(TURN_RATE);
                if (ticks_in_mode > TURN_TICKS) drive_mode = MODE_STOP;
            end
            default: ;
        endcase
        // forward term scaled up from integer to Q16.16
        fwd = vx * longint'(kf) * 256;
        ang = omega * longint'(kt);
        split_wheel(fwd - ang, r.left_dir, r.left_speed);
        split_wheel(fwd + ang, r.right_dir, r.right_speed);
        r.mode = drive_mode;
        wheel_cmds_due.push_back(r);
    endfunction

    task automatic check_wheel_cmd();
        t_wheel_cmd want;
        if (wheel_cmds_due.size() == 0) begin
            report_mismatch("result with none expected", i_mode_now, 0);
        end else begin
            want = wheel_cmds_due.pop_front();
            if (i_left_dir != want.left_dir)
                report_mismatch("left_dir", i_left_dir, want.left_dir);
            if (i_left_speed != want.left_speed)
                report_mismatch("left_speed", i_left_speed, want.left_speed);
            if (i_right_dir != want.right_dir)
                report_mismatch("right_dir", i_right_dir, want.right_dir);
            if (i_right_speed != want.right_speed)
                report_mismatch("right_speed", i_right_speed, want.right_speed);
            if (i_mode_now != want.mode)
                report_mismatch("mode_now", i_mode_now, want.mode);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drive_mode    = MODE_STOP;
            ticks_in_mode = '0;
            prev_err      = '0;
            kp            = PROP_GAIN_RST;
            kd            = DERIV_GAIN_RST;
            kf            = FORWARD_GAIN_RST;
            kt            = TURN_GAIN_RST;
            wheel_cmds_due.delete();
        end else begin
            // results come from older transactions, so retire before predicting
            if (i_out_valid && !i_out_stall) check_wheel_cmd();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:    kp = i_cfg_data;
                    REG_DERIV_GAIN:   kd = i_cfg_data;
                    REG_FORWARD_GAIN: kf = i_cfg_data;
                    REG_TURN_GAIN:    kt = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd) begin
                    // set mode: drop unknown modes, keep previous error
                    if (i_new_mode <= MODE_RIGHT) begin
                        drive_mode    = i_new_mode;
                        ticks_in_mode = '0;
                    end
                end else begin
                    predict_tick(i_line_error);
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= wheel_cmds_due.size();
    end

endmodule

// ===== verif/tb_line_follow_drive_sequencer_core.sv =====
module tb_line_follow_drive_sequencer_core;
    import lfds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_JUNK_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_JUNK_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_JUNK_C = 3'd7;
    localparam logic [IDX_W-1:0]  REG_SPARE   = 3'd7;

    localparam logic [ERR_W-1:0] ERR_MAX  = 11'h3FF;
    localparam logic [ERR_W-1:0] ERR_MIN  = 11'h400;
    localparam logic [ERR_W-1:0] ERR_ZERO = 11'h000;
    localparam logic [ERR_W-1:0] ERR_ONE  = 11'h001;
    localparam logic [ERR_W-1:0] ERR_NEG1 = 11'h7FF;

    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              cmd       = 1'b0;
    logic [ERR_W-1:0]  line_err  = '0;
    logic [MODE_W-1:0] new_mode  = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data  = '0;

    wire               in_stall;
    wire               out_valid;
    wire [DIR_W-1:0]   left_dir;
    wire [SPD_W-1:0]   left_speed;
    wire [DIR_W-1:0]   right_dir;
    wire [SPD_W-1:0]   right_speed;
    wire [MODE_W-1:0]  mode_now;
    wire               cfg_ready;
    int                fail_count;
    int                pending;

    int                items_done  = 0;
    int                calm_left   = 0;
    int                idle_cycles = 0;
    bit                hold_go     = 1'b0;
    bit                hold_done   = 1'b0;

    line_follow_drive_sequencer_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_line_error  (line_err),
        .i_new_mode    (new_mode),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_left_dir    (left_dir),
        .o_left_speed  (left_speed),
        .o_right_dir   (right_dir),
        .o_right_speed (right_speed),
        .o_mode_now    (mode_now),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    lfds_drive_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_line_error  (line_err),
        .i_new_mode    (new_mode),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_left_dir    (left_dir),
        .i_left_speed  (left_speed),
        .i_right_dir   (right_dir),
        .i_right_speed (right_speed),
        .i_mode_now    (mode_now),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [ERR_W-1:0] rand_err();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        v    = int'($urandom_range(0, 2047));
        if (pick == 0) return ERR_MIN;
        if (pick == 1) return ERR_MAX;
        if (pick < 6) v = int'($urandom_range(0, 80)) - 40;
        return v[ERR_W-1:0];
    endfunction

    // enter and leave on a falling edge
    task automatic push_item(input logic c, input logic [ERR_W-1:0] e,
                             input logic [MODE_W-1:0] m);
        int gap;
        gap = 0;
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 59) == 0) begin
            calm_left = $urandom_range(10, 40);
        end else if ($urandom_range(0, 2) == 0) begin
            gap = gap_len();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        line_err <= e;
        new_mode <= m;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (!(c == CMD_SET && m > MODE_RIGHT)) items_done++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] d,
                              input logic [GAIN_W-1:0] f, input logic [GAIN_W-1:0] t,
                              input bit stray);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_DERIV_GAIN, d);
        write_reg(REG_FORWARD_GAIN, f);
        write_reg(REG_TURN_GAIN, t);
        // unmapped index must leave every gain alone
        if (stray) write_reg(REG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int                r;
        int                n;
        logic [MODE_W-1:0] m;
        while (items_done < target) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                r = $urandom_range(0, 19);
                if (r < 7)       m = MODE_FOLLOW;
                else if (r < 11) m = MODE_FORWARD;
                else if (r < 14) m = MODE_LEFT;
                else if (r < 17) m = MODE_RIGHT;
                else             m = MODE_STOP;
                case (m)
                    MODE_FOLLOW:  n = $urandom_range(1, 30);
                    MODE_FORWARD: n = ($urandom_range(0, 2) == 0) ? $urandom_range(98, 104)
                                                                  : $urandom_range(1, 20);
                    MODE_LEFT,
                    MODE_RIGHT:   n = $urandom_range(0, 22);
                    default:      n = $urandom_range(1, 3);
                endcase
                push_item(CMD_SET, rand_err(), m);
                repeat (n) push_item(CMD_TICK, rand_err(), 3'($urandom_range(0, 7)));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_item(1'($urandom_range(0, 1)), rand_err(), 3'($urandom_range(0, 7)));
            end
        end
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        int stall_left;
        int run_left;
        bit quiet;
        stall_left = 0;
        run_left   = 0;
        quiet      = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                if (run_left == 0) begin
                    quiet    = ($urandom_range(0, 3) == 0);
                    run_left = $urandom_range(30, 120);
                end
                run_left--;
                if (stall_left > 0) begin
                    out_stall <= 1'b1;
                    stall_left--;
                end else begin
                    out_stall <= 1'b0;
                    if (!quiet && $urandom_range(0, 3) == 0) stall_left = gap_len();
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset gains, walk every mode
        push_item(CMD_TICK, ERR_ZERO, MODE_FOLLOW);
        push_item(CMD_SET, ERR_ZERO, MODE_FOLLOW);
        push_item(CMD_TICK, ERR_ZERO, MODE_STOP);
        push_item(CMD_TICK, ERR_MAX, MODE_STOP);
        push_item(CMD_TICK, ERR_MIN, MODE_STOP);
        push_item(CMD_TICK, ERR_NEG1, MODE_STOP);
        push_item(CMD_TICK, ERR_ONE, MODE_STOP);
        push_item(CMD_SET, ERR_MAX, MODE_JUNK_A);
        push_item(CMD_SET, ERR_MIN, MODE_JUNK_C);
        push_item(CMD_TICK, 11'd300, MODE_JUNK_B);
        push_item(CMD_SET, ERR_ZERO, MODE_FORWARD);
        push_item(CMD_TICK, ERR_MAX, MODE_STOP);
        push_item(CMD_TICK, ERR_MIN, MODE_STOP);
        push_item(CMD_SET, ERR_ZERO, MODE_LEFT);
        push_item(CMD_TICK, ERR_ZERO, MODE_STOP);
        push_item(CMD_SET, ERR_ZERO, MODE_RIGHT);
        push_item(CMD_TICK, ERR_ZERO, MODE_STOP);
        push_item(CMD_SET, ERR_ZERO, MODE_JUNK_B);
        push_item(CMD_TICK, ERR_ZERO, MODE_STOP);
        push_item(CMD_SET, ERR_ZERO, MODE_STOP);
        push_item(CMD_TICK, ERR_MAX, MODE_STOP);
        push_item(CMD_SET, ERR_ZERO, MODE_FOLLOW);
        push_item(CMD_TICK, 11'h738, MODE_STOP);
        run_random(PHASE_ITEMS);

        load_gains(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1);
        run_random(2 * PHASE_ITEMS);

        load_gains(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        run_random(3 * PHASE_ITEMS);

        load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        hold_go = 1'b1;
        run_random(4 * PHASE_ITEMS);

        load_gains(16'h0040, 16'h0200, 16'h0100, 16'h0080, 1'b0);
        run_random(5 * PHASE_ITEMS);

        load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        run_random(6 * PHASE_ITEMS);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== line_follow_drive_sequencer_core.f =====
rtl/core/lfds_pkg.sv
rtl/core/line_follow_drive_sequencer_core.sv
verif/lfds_drive_checker.sv
verif/tb_line_follow_drive_sequencer_core.sv
